### rtl/core/qpv_pkg.sv
// Shared constants, types and the quadrature transition decode for the
// position/velocity block. No dependencies.
`default_nettype none

package qpv_pkg;

  localparam int CPR_W     = 16;
  localparam int ELAPSED_W = 16;
  localparam int COUNT_W   = 16;
  localparam int ANGLE_W   = 15;
  localparam int SPEED_W   = 32;
  localparam int TIME_W    = 32;

  // Shared multiplier operand widths and product width.
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Shared divider: remainder, dividend/quotient shift register, step counter.
  localparam int DIV_REM_W  = 32;
  localparam int DIV_NUM_W  = 36;
  localparam int DIV_STEP_W = 6;

  // Quotient bits needed for the angle and the speed divisions.
  localparam logic [DIV_STEP_W-1:0] ANGLE_STEPS = DIV_STEP_W'(ANGLE_W);
  localparam logic [DIV_STEP_W-1:0] SPEED_STEPS = DIV_STEP_W'(DIV_NUM_W);

  // 2*pi in Q28 and microseconds per second.
  localparam logic [MUL_B_W-1:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [MUL_B_W-1:0] US_PER_S   = 31'd1000000;

  localparam logic [CPR_W-1:0] CPR_RESET = 16'd1024;

  // Count step codes.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_NUM_W-1:0]  num_init;
    logic [DIV_REM_W-1:0]  den;
    logic [DIV_STEP_W-1:0] steps;
  } div_cmd_t;

  // x4 decode: index is {last pair, new pair}; Gray order 0,1,3,2 counts up.
  function automatic logic [1:0] step_code(input logic [3:0] idx);
    logic [1:0] code;
    unique case (idx) inside
      4'd1, 4'd7, 4'd8, 4'd14:  code = STEP_UP;
      4'd2, 4'd4, 4'd11, 4'd13: code = STEP_DOWN;
      default:                  code = STEP_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### rtl/core/qpv_if.sv
// Valid/ready channel interfaces for encoder samples and decoded results.
// Depends on qpv_pkg.
`default_nettype none

interface qpv_in_if;
  logic                           valid;
  logic                           ready;
  logic                           phase_a;
  logic                           phase_b;
  logic [qpv_pkg::ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, output phase_a, output phase_b, output elapsed_us,
                  input ready);
  modport sink   (input valid, input phase_a, input phase_b, input elapsed_us,
                  output ready);
endinterface

interface qpv_out_if;
  logic                                valid;
  logic                                ready;
  logic        [qpv_pkg::COUNT_W-1:0]  count;
  logic        [qpv_pkg::ANGLE_W-1:0]  angle_q12;
  logic signed [qpv_pkg::SPEED_W-1:0]  speed_q12;
  logic                                moved;

  modport source (output valid, output count, output angle_q12, output speed_q12,
                  output moved, input ready);
  modport sink   (input valid, input count, input angle_q12, input speed_q12,
                  input moved, output ready);
endinterface

`default_nettype wire

### rtl/core/quadrature_position_velocity.sv
// Top level of the x4 quadrature position and velocity decoder.
// Depends on qpv_pkg, qpv_if (qpv_in_if, qpv_out_if) and qpv_div.
`default_nettype none

// Each sample beat carries the A/B phase levels and the microseconds since the
// previous sample; each one gives exactly one result beat with the wrapped
// count, the shaft angle (unsigned Q3.12 rad), the last velocity (signed Q12
// rad/s, saturated) and a moved flag. The first sample after reset only
// latches the phases. A sample with no phase change goes from idle to the done
// state, then to the output register; one that moves the shaft also uses one
// shared 16x31 multiplier and one shared restoring divider (15 steps for the
// angle, 36 for the velocity). The sample side is ready only while the
// sequencer is idle; a finished result sits in the output register and
// does not block the next sample from being taken. The user must write
// counts_per_rev via cfg_we/cfg_wdata only while idle (unenforced); zero is one.
module quadrature_position_velocity (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [qpv_pkg::CPR_W-1:0]   cfg_wdata,
  qpv_in_if.sink                           sample,
  qpv_out_if.source                        result
);
  import qpv_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ANG_MUL  = 3'd1;
  localparam logic [2:0] S_ANG_LOAD = 3'd2;
  localparam logic [2:0] S_ANG_DIV  = 3'd3;
  localparam logic [2:0] S_SPD_MUL  = 3'd4;
  localparam logic [2:0] S_SPD_LOAD = 3'd5;
  localparam logic [2:0] S_SPD_DIV  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  logic [2:0]           state;
  logic [CPR_W-1:0]     cpr;
  logic [1:0]           last_phases;
  logic                 primed;
  logic [COUNT_W-1:0]   count;
  logic [ANGLE_W-1:0]   angle;
  logic [SPEED_W-1:0]   speed;
  logic [TIME_W-1:0]    taccum;
  logic                 moved;
  logic                 dang_neg;
  logic [ANGLE_W-1:0]   dang_abs;
  logic [PROD_W-1:0]    prod;

  logic                 out_valid;
  logic [COUNT_W-1:0]   out_count;
  logic [ANGLE_W-1:0]   out_angle;
  logic [SPEED_W-1:0]   out_speed;
  logic                 out_moved;

  logic                 accept;
  logic [1:0]           pair;
  logic [CPR_W-1:0]     cpr_eff;
  logic [TIME_W:0]      accum_sum;
  logic [TIME_W-1:0]    accum_sat;
  logic [1:0]           step;
  logic [COUNT_W:0]     count_step;
  logic [COUNT_W-1:0]   count_next;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W:0]      ang_num;
  logic [DIV_NUM_W-1:0] spd_num;
  logic [ANGLE_W-1:0]   angle_new;
  logic [ANGLE_W:0]     dang;
  logic [DIV_NUM_W-1:0] q;
  logic [SPEED_W-1:0]   speed_div;
  logic                 div_busy;
  div_cmd_t             div_cmd;

  assign accept  = sample.valid && sample.ready;
  assign pair    = {sample.phase_b, sample.phase_a};
  assign cpr_eff = (cpr == '0) ? CPR_W'(1) : cpr;

  // Saturating time accumulation.
  assign accum_sum = {1'b0, taccum} + (TIME_W+1)'(sample.elapsed_us);
  assign accum_sat = accum_sum[TIME_W] ? {TIME_W{1'b1}} : accum_sum[TIME_W-1:0];

  // Count update with wrap: below zero goes to counts_per_rev, above goes to 0.
  assign step = step_code({last_phases, pair});
  always_comb begin
    count_step = {1'b0, count};
    case (step)
      STEP_UP:   count_step = {1'b0, count} + 1'b1;
      STEP_DOWN: count_step = {1'b0, count} - 1'b1;
      default:   count_step = {1'b0, count};
    endcase
    if (step == STEP_DOWN && count == '0) begin
      count_next = cpr_eff;
    end else if (count_step > {1'b0, cpr_eff}) begin
      count_next = '0;
    end else begin
      count_next = count_step[COUNT_W-1:0];
    end
  end

  // Shared multiplier: count*2pi for the angle, |delta angle|*1e6 for speed.
  assign mul_a = (state == S_SPD_MUL) ? MUL_A_W'(dang_abs) : count;
  assign mul_b = (state == S_SPD_MUL) ? US_PER_S : TWO_PI_Q28;

  // Angle dividend with half-divisor rounding; speed dividend likewise.
  assign ang_num = {1'b0, prod} + ((PROD_W+1)'(cpr_eff) << 15);
  assign spd_num = prod[DIV_NUM_W-1:0] + DIV_NUM_W'(taccum[TIME_W-1:1]);

  // The angle quotient is below 2^15, so the dividend's top bits start as
  // the remainder and only 15 steps remain.
  always_comb begin
    div_cmd = '0;
    if (state == S_ANG_LOAD) begin
      div_cmd.start    = 1'b1;
      div_cmd.rem_init = DIV_REM_W'(ang_num[PROD_W:31]);
      div_cmd.num_init = {ang_num[30:16], {(DIV_NUM_W-15){1'b0}}};
      div_cmd.den      = DIV_REM_W'(cpr_eff);
      div_cmd.steps    = ANGLE_STEPS;
    end else if (state == S_SPD_LOAD && taccum != '0) begin
      div_cmd.start    = 1'b1;
      div_cmd.rem_init = '0;
      div_cmd.num_init = spd_num;
      div_cmd.den      = taccum;
      div_cmd.steps    = SPEED_STEPS;
    end
  end

  qpv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .busy (div_busy),
    .quot (q)
  );

  assign angle_new = q[ANGLE_W-1:0];
  assign dang      = {1'b0, angle_new} - {1'b0, angle};

  // Round-half-away quotient, signed and saturated.
  always_comb begin
    if (dang_neg) begin
      speed_div = (q > DIV_NUM_W'(SPEED_MIN)) ? SPEED_MIN : -q[SPEED_W-1:0];
    end else begin
      speed_div = (q > DIV_NUM_W'(SPEED_MAX)) ? SPEED_MAX : q[SPEED_W-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cpr         <= CPR_RESET;
      last_phases <= '0;
      primed      <= 1'b0;
      count       <= '0;
      angle       <= '0;
      speed       <= '0;
      taccum      <= '0;
      moved       <= 1'b0;
    end else begin
      if (cfg_we) begin
        cpr <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            moved <= 1'b0;
            state <= S_DONE;
            if (!primed) begin
              // First sample: latch the phases only.
              last_phases <= pair;
              primed      <= 1'b1;
            end else begin
              taccum <= accum_sat;
              if (pair != last_phases) begin
                count       <= count_next;
                last_phases <= pair;
                moved       <= 1'b1;
                state       <= S_ANG_MUL;
              end
            end
          end
        end
        S_ANG_MUL:  state <= S_ANG_LOAD;
        S_ANG_LOAD: state <= S_ANG_DIV;
        S_ANG_DIV: begin
          if (!div_busy) begin
            angle <= angle_new;
            state <= S_SPD_MUL;
          end
        end
        S_SPD_MUL:  state <= S_SPD_LOAD;
        S_SPD_LOAD: begin
          if (taccum == '0) begin
            // No elapsed time: pin to the rail by direction.
            if (dang_abs == '0) begin
              speed <= '0;
            end else begin
              speed <= dang_neg ? SPEED_MIN : SPEED_MAX;
            end
            state <= S_DONE;
          end else begin
            state <= S_SPD_DIV;
          end
        end
        S_SPD_DIV: begin
          if (!div_busy) begin
            speed  <= speed_div;
            taccum <= '0;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Angle delta and product registers.
  always_ff @(posedge clk) begin
    if (state == S_ANG_DIV && !div_busy) begin
      dang_neg <= dang[ANGLE_W];
      dang_abs <= dang[ANGLE_W] ? -dang[ANGLE_W-1:0] : dang[ANGLE_W-1:0];
    end
    if (state == S_ANG_MUL || state == S_SPD_MUL) begin
      prod <= mul_a * mul_b;
    end
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || result.ready)) begin
      out_count <= count;
      out_angle <= angle;
      out_speed <= speed;
      out_moved <= moved;
    end
  end

  assign sample.ready     = state == S_IDLE;
  assign result.valid     = out_valid;
  assign result.count     = out_count;
  assign result.angle_q12 = out_angle;
  assign result.speed_q12 = out_speed;
  assign result.moved     = out_moved;

endmodule

`default_nettype wire

### rtl/core/qpv_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on qpv_pkg.
`default_nettype none

module qpv_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire qpv_pkg::div_cmd_t                 cmd,
  output logic                                   busy,
  output logic [qpv_pkg::DIV_NUM_W-1:0]          quot
);
  import qpv_pkg::*;

  logic [DIV_REM_W-1:0]  rem;
  logic [DIV_NUM_W-1:0]  numsh;
  logic [DIV_REM_W-1:0]  den;
  logic [DIV_STEP_W-1:0] left;

  logic [DIV_REM_W:0]    trial;
  logic [DIV_REM_W:0]    diff;
  logic                  ge;

  // Shift in the next dividend bit and try to subtract.
  assign trial = {rem, numsh[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (cmd.start) begin
      left <= cmd.steps;
    end else if (left != '0) begin
      left <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem   <= cmd.rem_init;
      numsh <= cmd.num_init;
      den   <= cmd.den;
    end else if (left != '0) begin
      rem   <= ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      numsh <= {numsh[DIV_NUM_W-2:0], ge};
    end
  end

  assign busy = left != '0;
  assign quot = numsh;

endmodule

`default_nettype wire
